// ----- src/msxt_pkg.sv -----
// shared types and constants for the max subarray xor trie block
// no dependencies; imported by every module of the block
package msxt_pkg;

	// width of one array element and of the result value
	localparam int VALUE_W = 30;
	// stream data width, element padded to whole bytes
	localparam int TDATA_W = 32;

	// node memory control from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en0;
		logic wr_en1;
	} mem_ctl_t;

	// one result item
	typedef struct packed {
		logic [VALUE_W-1:0] best_xor;
		logic               set_done;
		logic               store_full;
	} result_t;

endpackage

// ----- src/msxt_node_mem.sv -----
// trie node store: two banks holding the child links of every node
// (bank b, row n = child of node n along bit b); depends on msxt_pkg
module msxt_node_mem import msxt_pkg::*; #(
	parameter int DEPTH  = 16384,
	parameter int NODE_W = 14
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [NODE_W-1:0] rd_node,
	input  logic [NODE_W-1:0] wr_node,
	input  logic [NODE_W-1:0] wr_data,
	output logic [NODE_W-1:0] rd_child0,
	output logic [NODE_W-1:0] rd_child1
);

	logic [NODE_W-1:0] child0_q [DEPTH];
	logic [NODE_W-1:0] child1_q [DEPTH];
	logic [NODE_W-1:0] rd_child0_q;
	logic [NODE_W-1:0] rd_child1_q;

	// one write per bank, both banks read at the same node, registered data
	always_ff @(posedge clk) begin
		if (ctl.wr_en0) begin
			child0_q[wr_node] <= wr_data;
		end
		if (ctl.wr_en1) begin
			child1_q[wr_node] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_child0_q <= child0_q[rd_node];
			rd_child1_q <= child1_q[rd_node];
		end
	end

	assign rd_child0 = rd_child0_q;
	assign rd_child1 = rd_child1_q;

endmodule

// ----- src/msxt_ctrl.sv -----
// sequencer: prefix xor, trie insert walk, node allocation, greedy query walk,
// running best and set restart; depends on msxt_pkg, drives msxt_node_mem
module msxt_ctrl import msxt_pkg::*; #(
	parameter int KEY_BITS   = 30,
	parameter int NODE_DEPTH = 32768,
	parameter int NODE_W     = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] in_value,
	input  logic               in_last,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res,
	output mem_ctl_t           mem_ctl,
	output logic [NODE_W-1:0]  rd_node,
	output logic [NODE_W-1:0]  wr_node,
	output logic [NODE_W-1:0]  wr_data,
	input  logic [NODE_W-1:0]  rd_child0,
	input  logic [NODE_W-1:0]  rd_child1
);

	localparam int NODE_CAP = NODE_DEPTH / 2;
	localparam int CW = $clog2(NODE_CAP + 1);
	localparam int LW = $clog2(KEY_BITS + 1);
	localparam int BW = $clog2(KEY_BITS);
	localparam int SW = ((CW > LW) ? CW : LW) + 1;

	typedef enum logic [8:0] {
		S_IDLE       = 9'b000000001,
		S_CLR_ROOT   = 9'b000000010,
		S_INS_READ   = 9'b000000100,
		S_INS_WALK   = 9'b000001000,
		S_ALLOC_CLR  = 9'b000010000,
		S_ALLOC_LINK = 9'b000100000,
		S_QRY_READ   = 9'b001000000,
		S_QRY_WALK   = 9'b010000000,
		S_FINISH     = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [VALUE_W-1:0]  prefix_q;
	logic [VALUE_W-1:0]  best_q;
	logic                full_q;
	logic                last_q;
	logic                seed_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [NODE_W-1:0]   node_q;
	logic [LW-1:0]       lvl_q;
	logic [CW-1:0]       used_q;

	logic [VALUE_W-1:0]  prefix_next;
	logic [KEY_BITS-1:0] key_next;
	logic [VALUE_W-1:0]  acc_val;
	logic [VALUE_W-1:0]  best_new;
	logic [LW-1:0]       lvl_dec;
	logic [BW-1:0]       bidx;
	logic                key_bit;
	logic                lvl_zero;
	logic                fits;
	logic [NODE_W-1:0]   child_same;
	logic [NODE_W-1:0]   child_opp;
	logic [NODE_W-1:0]   new_node;
	state_t              after_insert;

	// key is the prefix resized to the key width
	assign prefix_next = prefix_q ^ in_value;
	for (genvar i = 0; i < KEY_BITS; i++) begin : g_key
		if (i < VALUE_W) begin : g_val
			assign key_next[i] = prefix_next[i];
		end else begin : g_zero
			assign key_next[i] = 1'b0;
		end
	end

	// query result resized back to the value width
	for (genvar i = 0; i < VALUE_W; i++) begin : g_acc
		if (i < KEY_BITS) begin : g_key_bit
			assign acc_val[i] = acc_q[i];
		end else begin : g_zero
			assign acc_val[i] = 1'b0;
		end
	end

	// current level decode and child selection
	assign lvl_dec    = lvl_q - LW'(1);
	assign bidx       = lvl_dec[BW-1:0];
	assign key_bit    = key_q[bidx];
	assign lvl_zero   = (lvl_q == '0);
	assign child_same = key_bit ? rd_child1 : rd_child0;
	assign child_opp  = key_bit ? rd_child0 : rd_child1;
	assign new_node   = used_q[NODE_W-1:0];

	// remaining levels need that many new nodes
	assign fits = (SW'(used_q) + SW'(lvl_q)) <= SW'(NODE_CAP);

	assign best_new     = (acc_val > best_q) ? acc_val : best_q;
	assign after_insert = seed_q ? S_IDLE : S_QRY_READ;

	// memory requests
	always_comb begin
		mem_ctl = '0;
		rd_node = '0;
		wr_node = '0;
		wr_data = '0;
		case (state_q)
			S_CLR_ROOT: begin
				mem_ctl.wr_en0 = 1'b1;
				mem_ctl.wr_en1 = 1'b1;
			end
			S_INS_READ, S_QRY_READ: begin
				mem_ctl.rd_en = 1'b1;
			end
			S_INS_WALK: begin
				if (!lvl_zero && child_same != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_node       = child_same;
				end
			end
			S_ALLOC_CLR: begin
				mem_ctl.wr_en0 = 1'b1;
				mem_ctl.wr_en1 = 1'b1;
				wr_node        = new_node;
			end
			S_ALLOC_LINK: begin
				mem_ctl.wr_en0 = !key_bit;
				mem_ctl.wr_en1 = key_bit;
				wr_node        = node_q;
				wr_data        = new_node;
			end
			S_QRY_WALK: begin
				if (!lvl_zero && child_opp != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_node       = child_opp;
				end else if (!lvl_zero && child_same != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_node       = child_same;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_ROOT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_INS_READ;
					end
				end
				S_CLR_ROOT: begin
					state_q <= S_INS_READ;
				end
				S_INS_READ: begin
					state_q <= S_INS_WALK;
				end
				S_INS_WALK: begin
					if (lvl_zero) begin
						state_q <= after_insert;
					end else if (child_same == '0) begin
						state_q <= fits ? S_ALLOC_CLR : after_insert;
					end
				end
				S_ALLOC_CLR: begin
					state_q <= S_ALLOC_LINK;
				end
				S_ALLOC_LINK: begin
					state_q <= (lvl_q == LW'(1)) ? after_insert : S_ALLOC_CLR;
				end
				S_QRY_READ: begin
					state_q <= S_QRY_WALK;
				end
				S_QRY_WALK: begin
					if (lvl_zero || (child_opp == '0 && child_same == '0)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= last_q ? S_CLR_ROOT : S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLR_ROOT;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					prefix_q <= prefix_next;
					key_q    <= key_next;
					last_q   <= in_last;
					seed_q   <= 1'b0;
				end
			end
			S_CLR_ROOT: begin
				prefix_q <= '0;
				best_q   <= '0;
				full_q   <= 1'b0;
				key_q    <= '0;
				seed_q   <= 1'b1;
				used_q   <= CW'(1);
			end
			S_INS_READ, S_QRY_READ: begin
				node_q <= '0;
				lvl_q  <= LW'(KEY_BITS);
				acc_q  <= '0;
			end
			S_INS_WALK: begin
				if (!lvl_zero) begin
					if (child_same != '0) begin
						node_q <= child_same;
						lvl_q  <= lvl_dec;
					end else if (!fits) begin
						full_q <= 1'b1;
					end
				end
			end
			S_ALLOC_LINK: begin
				node_q <= new_node;
				used_q <= used_q + CW'(1);
				lvl_q  <= lvl_dec;
			end
			S_QRY_WALK: begin
				if (!lvl_zero) begin
					if (child_opp != '0) begin
						acc_q[bidx] <= 1'b1;
						node_q      <= child_opp;
						lvl_q       <= lvl_dec;
					end else if (child_same != '0) begin
						node_q <= child_same;
						lvl_q  <= lvl_dec;
					end
				end
			end
			S_FINISH: begin
				if (res_ready) begin
					best_q <= best_new;
				end
			end
			default: begin
			end
		endcase
	end

	// handshakes and result
	assign in_ready       = (state_q == S_IDLE);
	assign res_valid      = (state_q == S_FINISH);
	assign res.best_xor   = best_new;
	assign res.set_done   = last_q;
	assign res.store_full = full_q;

endmodule

// ----- src/max_subarray_xor_trie_core.sv -----
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata = value, s_tlast = last_item
// m_*      out  m_tvalid/m_tready  m_tdata = best_xor, m_tlast = set_done,
//                                  m_tuser = store_full
//
// for an item, the insert walk and the query walk each read one trie level
// per cycle through the node memory read port, and every new node costs two
// writes, one to clear it and one to link it from its parent.
// reset, and every item with s_tlast, is followed by a trie restart that
// writes the root and the path of prefix 0.
// a result waits in the output register; the next item is taken meanwhile,
// but its result holds the sequencer until the register frees.
//
// top level of the max subarray xor trie block; depends on msxt_pkg,
// msxt_node_mem and msxt_ctrl
module max_subarray_xor_trie_core import msxt_pkg::*; #(
	parameter int KEY_BITS   = 30,
	parameter int NODE_DEPTH = 32768
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [29:0] value, [31:30] zero
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [29:0] best_xor, [31:30] zero
	output logic               m_tlast,
	output logic               m_tuser    // [0] store_full
);

	localparam int NODE_CAP = NODE_DEPTH / 2;
	localparam int NODE_W   = $clog2(NODE_CAP);

	mem_ctl_t          mem_ctl;
	logic [NODE_W-1:0] rd_node;
	logic [NODE_W-1:0] wr_node;
	logic [NODE_W-1:0] wr_data;
	logic [NODE_W-1:0] rd_child0;
	logic [NODE_W-1:0] rd_child1;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	msxt_node_mem #(
		.DEPTH  (NODE_CAP),
		.NODE_W (NODE_W)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.rd_node   (rd_node),
		.wr_node   (wr_node),
		.wr_data   (wr_data),
		.rd_child0 (rd_child0),
		.rd_child1 (rd_child1)
	);

	msxt_ctrl #(
		.KEY_BITS   (KEY_BITS),
		.NODE_DEPTH (NODE_DEPTH),
		.NODE_W     (NODE_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.in_last   (s_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.rd_node   (rd_node),
		.wr_node   (wr_node),
		.wr_data   (wr_data),
		.rd_child0 (rd_child0),
		.rd_child1 (rd_child1)
	);

	// output register between sequencer and master side
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - VALUE_W){1'b0}}, out_q.best_xor};
	assign m_tlast  = out_q.set_done;
	assign m_tuser  = out_q.store_full;

endmodule

// ----- bench/tb_max_subarray_xor_trie_core.sv -----
`timescale 1ns / 1ps
// stream testbench for max_subarray_xor_trie_core: directed table then random sets
// scored against an in-bench prefix-xor trie predictor; depends on msxt_pkg
module tb_max_subarray_xor_trie_core import msxt_pkg::*;;

	localparam int KEY_BITS   = 30;
	localparam int NODE_DEPTH = 32768;
	localparam int NODE_CAP   = NODE_DEPTH / 2;
	localparam int RAND_ITEMS = 1300;
	localparam int LONG_SET   = 820;
	localparam int STALL_MAX  = 4000;
	localparam int TAIL_WAIT  = 300;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	// one directed item, with an optional typed-in expected result
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               typed;
		logic [VALUE_W-1:0] best;
		logic               full;
	} stim_row_t;

	localparam int DIR_N = 16;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		'{30'h0000_0000, 1'b1, 1'b1, 30'h0000_0000, 1'b0},
		'{ALL_ONES,      1'b1, 1'b1, ALL_ONES,      1'b0},
		'{ALL_ONES,      1'b0, 1'b1, ALL_ONES,      1'b0},
		'{ALL_ONES,      1'b1, 1'b1, ALL_ONES,      1'b0},
		'{30'h0000_0001, 1'b0, 1'b0, 30'h0,         1'b0},
		'{30'h0000_0002, 1'b0, 1'b0, 30'h0,         1'b0},
		'{30'h2000_0000, 1'b0, 1'b0, 30'h0,         1'b0},
		'{30'h0000_0000, 1'b0, 1'b0, 30'h0,         1'b0},
		'{30'h1555_5555, 1'b0, 1'b0, 30'h0,         1'b0},
		'{30'h2AAA_AAAA, 1'b1, 1'b0, 30'h0,         1'b0},
		'{30'h0000_0001, 1'b1, 1'b1, 30'h0000_0001, 1'b0},
		'{30'h2000_0000, 1'b1, 1'b1, 30'h2000_0000, 1'b0},
		'{30'h0000_0000, 1'b0, 1'b1, 30'h0000_0000, 1'b0},
		'{30'h0000_0000, 1'b0, 1'b1, 30'h0000_0000, 1'b0},
		'{30'h0000_0000, 1'b1, 1'b1, 30'h0000_0000, 1'b0},
		'{30'h3FFF_0000, 1'b1, 1'b1, 30'h3FFF_0000, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic               m_tuser;

	// predictor state: child links, node count, running prefix, best, full flag
	int unsigned        link_mem [NODE_DEPTH];
	int unsigned        node_count;
	logic [VALUE_W-1:0] run_xor;
	logic [VALUE_W-1:0] best_val;
	logic               store_flag;

	result_t            pending_results [$];
	int                 mismatch_cnt;
	int                 idle_cycles;

	// what the item now on the bus expects, when typed in
	logic               cur_typed;
	logic [VALUE_W-1:0] cur_best;
	logic               cur_full;

	int                 snd_quiet;
	int                 rcv_quiet;

	max_subarray_xor_trie_core #(
		.KEY_BITS  (KEY_BITS),
		.NODE_DEPTH(NODE_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// insert one key, all or nothing when the node budget runs out
	function automatic void trie_add(input logic [VALUE_W-1:0] key);
		int unsigned node;
		int unsigned child;
		int unsigned fresh;
		int unsigned need;
		int          lvl;
		node = 0;
		lvl  = KEY_BITS - 1;
		while (lvl >= 0) begin
			child = link_mem[2 * node + key[lvl]];
			if (child == 0)
				break;
			node = child;
			lvl--;
		end
		need = lvl + 1;
		if (need == 0)
			return;
		if (node_count > NODE_CAP || need > NODE_CAP - node_count) begin
			store_flag = 1'b1;
			return;
		end
		while (lvl >= 0) begin
			fresh = node_count;
			node_count++;
			link_mem[2 * fresh]     = 0;
			link_mem[2 * fresh + 1] = 0;
			link_mem[2 * node + key[lvl]] = fresh;
			node = fresh;
			lvl--;
		end
	endfunction

	// greedy walk, opposite bit first, stop at a dead end
	function automatic logic [VALUE_W-1:0] trie_best_match(input logic [VALUE_W-1:0] key);
		int unsigned        node;
		int unsigned        child;
		logic [VALUE_W-1:0] acc;
		node = 0;
		acc  = '0;
		for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
			child = link_mem[2 * node + (key[lvl] ^ 1'b1)];
			if (child != 0) begin
				acc[lvl] = 1'b1;
				node = child;
			end else begin
				child = link_mem[2 * node + key[lvl]];
				if (child == 0)
					break;
				node = child;
			end
		end
		return acc;
	endfunction

	// empty trie holding only prefix 0
	function automatic void trie_restart();
		run_xor     = '0;
		best_val    = '0;
		store_flag  = 1'b0;
		link_mem[0] = 0;
		link_mem[1] = 0;
		node_count  = 1;
		trie_add('0);
	endfunction

	// running maximum subarray xor for one element
	function automatic result_t xor_trie_predict(input logic [VALUE_W-1:0] value,
			input logic last);
		result_t            res;
		logic [VALUE_W-1:0] hit;
		run_xor = run_xor ^ value;
		trie_add(run_xor);
		hit = trie_best_match(run_xor);
		if (hit > best_val)
			best_val = hit;
		res.best_xor   = best_val;
		res.set_done   = last;
		res.store_full = store_flag;
		if (last)
			trie_restart();
		return res;
	endfunction

	// element mix: plain random, small, one-hot, near all ones
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = VALUE_W'($urandom_range(0, 15));
			1: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			2: v = ALL_ONES ^ VALUE_W'($urandom_range(0, 15));
			default: v = VALUE_W'($urandom());
		endcase
		return v;
	endfunction

	// drive one item at the falling edge and hold it until taken
	task automatic send_item(input logic [VALUE_W-1:0] value, input logic last,
			input logic typed, input logic [VALUE_W-1:0] best, input logic full);
		int gap;
		if (snd_quiet > 0) begin
			snd_quiet--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 15) == 0)
				snd_quiet = $urandom_range(10, 40);
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata   = {{(TDATA_W - VALUE_W){1'b0}}, value};
		s_tlast   = last;
		cur_typed = typed;
		cur_best  = best;
		cur_full  = full;
		s_tvalid  = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// record the expectation of every accepted item
	always @(posedge clk) begin
		result_t res;
		if (arst_n && s_tvalid && s_tready) begin
			res = xor_trie_predict(s_tdata[VALUE_W-1:0], s_tlast);
			if (cur_typed) begin
				res.best_xor   = cur_best;
				res.set_done   = s_tlast;
				res.store_full = cur_full;
			end
			pending_results = {pending_results, res};
		end
	end

	// score each result against the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item: best_xor %h", m_tdata[VALUE_W-1:0]);
				mismatch_cnt++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[VALUE_W-1:0] !== exp_res.best_xor) begin
					$error("best_xor: expected %h, got %h", exp_res.best_xor,
						m_tdata[VALUE_W-1:0]);
					mismatch_cnt++;
				end
				if (m_tlast !== exp_res.set_done) begin
					$error("set_done: expected %b, got %b", exp_res.set_done, m_tlast);
					mismatch_cnt++;
				end
				if (m_tuser !== exp_res.store_full) begin
					$error("store_full: expected %b, got %b", exp_res.store_full, m_tuser);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver with random back-pressure
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rcv_quiet > 0) begin
				rcv_quiet--;
				gap = 0;
			end else begin
				if ($urandom_range(0, 15) == 0)
					rcv_quiet = $urandom_range(10, 40);
				gap = $urandom_range(0, 12);
			end
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			@(negedge clk);
		end
	end

	// reset, directed table, random sets, drain
	initial begin
		int sent;
		int len;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		cur_typed    = 1'b0;
		cur_best     = '0;
		cur_full     = 1'b0;
		mismatch_cnt = 0;
		idle_cycles  = 0;
		snd_quiet    = 0;
		rcv_quiet    = 0;
		foreach (link_mem[i])
			link_mem[i] = 0;
		trie_restart();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIR_N; r++)
			send_item(DIR_ROWS[r].value, DIR_ROWS[r].last, DIR_ROWS[r].typed,
				DIR_ROWS[r].best, DIR_ROWS[r].full);

		// one long set that runs the node store dry
		for (int k = 0; k < LONG_SET; k++)
			send_item(VALUE_W'($urandom()), k == LONG_SET - 1, 1'b0, '0, 1'b0);
		sent = LONG_SET;

		// short sets of mixed content, an occasional longer one
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(13, 60);
			else
				len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				send_item(pick_value(), k == len - 1, 1'b0, '0, 1'b0);
			sent += len;
		end
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
